// ----- sv/vggs_pkg.sv -----
// Shared types and constants for the voice gate, gain and soft clip block.
// Used by vggs_mul, vggs_div and voice_gate_gain_softclip_top; depends on nothing.
package vggs_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Shared divider widths.
    localparam int DIV_D_W = 36;
    localparam int DIV_Q_W = 32;
    localparam int DIV_N_W = 5;

    // Datapath widths and limits.
    localparam int ACC_W   = 20;
    localparam int ENV_W   = 19;
    localparam int ACC_MAX = 524287;

    localparam int DC_POLE_Q16   = 65208;
    localparam int SAFE_GAIN_Q16 = 70779;
    localparam int OUT_SCALE     = 32767;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_DRIVE_GAIN     = 2'd0,
        CFG_ATTACK_COEF    = 2'd1,
        CFG_RELEASE_COEF   = 2'd2,
        CFG_GATE_THRESHOLD = 2'd3
    } cfg_idx_t;

    localparam logic [15:0] DRIVE_GAIN_RST     = 16'd6758;
    localparam logic [15:0] ATTACK_COEF_RST    = 16'd16384;
    localparam logic [15:0] RELEASE_COEF_RST   = 16'd64553;
    localparam logic [14:0] GATE_THRESHOLD_RST = 15'd5898;

    // Request to the shared divider.
    typedef struct packed {
        logic               start;
        logic               lsb;
        logic [DIV_N_W-1:0] nbits;
    } div_req_t;

endpackage

// ----- sv/voice_gate_gain_softclip_top.sv -----
// Voice gate with gain and soft clip: DC blocker, envelope follower, noise gate,
// drive gain, hard clip and a nine-level continued-fraction tanh, one sample a beat.
// A result beat is registered from S_OUT; when the gate is closed the gate gain first
// needs a 16-bit-quotient division and the cube, and the nine 31-bit-quotient tanh
// divisions on the shared divider make up most of the work. A new sample is taken
// only once the sequencer is back in S_IDLE, so in_stall holds while a sample is in
// work and also while out_stall holds the previous result beat.
// Reset is asynchronous and active low: filter state clears to zero, registers load defaults.
module voice_gate_gain_softclip_top
#(
    parameter int SAMPLE_WIDTH = vggs_pkg::SAMPLE_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [15:0]             out_sample,
    output logic [vggs_pkg::ENV_W-1:0]     envelope_level,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [15:0]                    cfg_data
);

    // The sequencer walks each sample through the shared multiplier (product
    // registered, used in the following state) and the shared divider.
    typedef enum logic [4:0] {
        S_IDLE, S_DC, S_ENV_MUL, S_ENV, S_GATE, S_GDIV, S_RR, S_R2, S_R3,
        S_DMUL, S_D, S_PMUL, S_P, S_GMUL, S_G, S_X2MUL, S_X2,
        S_TSTART, S_TDIV, S_FMUL, S_FSTART, S_FDIV, S_OUT
    } state_t;

    localparam int PW = vggs_pkg::MUL_P_W;
    localparam logic signed [PW-1:0] HALF16 = PW'(64'sd32768);
    localparam logic signed [PW-1:0] HALF12 = PW'(64'sd2048);
    localparam logic signed [PW-1:0] HALF32 = PW'(64'sd2147483648);

    // Configuration registers.
    logic [15:0] drive_reg, drive_next;
    logic [15:0] attack_reg, attack_next;
    logic [15:0] release_reg, release_next;
    logic [14:0] thr_reg, thr_next;

    // Sequencer state and datapath registers.
    state_t                          state_reg, state_next;
    logic signed [15:0]              x_reg, x_next;
    logic signed [15:0]              prev_in_reg, prev_in_next;
    logic signed [19:0]              prev_dc_reg, prev_dc_next;
    logic signed [19:0]              y_reg, y_next;
    logic [vggs_pkg::ENV_W-1:0]      env_reg, env_next;
    logic [15:0]                     r_reg, r_next;
    logic [16:0]                     gain_reg, gain_next;
    logic signed [19:0]              d_reg, d_next;
    logic signed [16:0]              p_reg, p_next;
    logic [15:0]                     ax_reg, ax_next;
    logic                            neg_reg, neg_next;
    logic [30:0]                     x2_reg, x2_next;
    logic [vggs_pkg::DIV_D_W-1:0]    t_reg, t_next;
    logic [3:0]                      k_reg, k_next;
    logic signed [15:0]              res_reg, res_next;
    logic signed [15:0]              out_sample_reg, out_sample_next;
    logic [vggs_pkg::ENV_W-1:0]      out_env_reg, out_env_next;
    logic                            out_valid_reg, out_valid_next;

    // Shared units.
    logic signed [vggs_pkg::MUL_A_W-1:0] mul_a;
    logic signed [vggs_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0]                mul_p;
    vggs_pkg::div_req_t                  div_req;
    logic [vggs_pkg::DIV_D_W-1:0]        div_den;
    logic [vggs_pkg::DIV_D_W-1:0]        div_rem0;
    logic                                div_busy;
    logic [vggs_pkg::DIV_Q_W-1:0]        div_quot;

    // Input conversion to Q15: shifting up by 16 and floor-shifting down by the
    // sample width covers both narrow and wide samples.
    logic signed [SAMPLE_WIDTH+15:0] x_wide;
    logic signed [SAMPLE_WIDTH+15:0] x_shift;
    logic signed [15:0]              x_q15;

    assign x_wide  = {in_sample, 16'b0};
    assign x_shift = x_wide >>> SAMPLE_WIDTH;
    assign x_q15   = x_shift[15:0];

    // Rounded views of the product.
    logic signed [PW-1:0] rnd16;
    logic signed [PW-1:0] rnd12;
    logic signed [PW-1:0] cube;

    assign rnd16 = (mul_p + HALF16) >>> 16;
    assign rnd12 = (mul_p + HALF12) >>> 12;
    assign cube  = (mul_p + HALF32) >>> 32;

    // DC blocker sum, saturated to 20 bits.
    logic signed [23:0] dc_sum;
    logic signed [19:0] dc_sat;

    assign dc_sum = 24'(x_reg) - 24'(prev_in_reg) + 24'(rnd16);
    always_comb
    begin
        if (dc_sum > 24'sd524287)
        begin
            dc_sat = 20'sd524287;
        end
        else if (dc_sum < -24'sd524288)
        begin
            dc_sat = -20'sd524288;
        end
        else
        begin
            dc_sat = dc_sum[19:0];
        end
    end

    // Envelope follower: magnitude, difference and weight.
    logic signed [20:0]          y_ext;
    logic signed [20:0]          y_mag;
    logic [vggs_pkg::ENV_W-1:0]  a_val;
    logic signed [20:0]          env_diff;
    logic [16:0]                 env_coef;
    logic signed [23:0]          env_sum;
    logic [vggs_pkg::ENV_W-1:0]  env_clamped;

    assign y_ext    = 21'(y_reg);
    assign y_mag    = y_ext[20] ? -y_ext : y_ext;
    assign a_val    = (y_mag > 21'sd524287) ? vggs_pkg::ENV_W'(vggs_pkg::ACC_MAX)
                                            : y_mag[vggs_pkg::ENV_W-1:0];
    assign env_diff = $signed({2'b0, a_val}) - $signed({2'b0, env_reg});
    assign env_coef = (a_val > env_reg) ? {1'b0, attack_reg}
                                        : 17'(18'd65536 - {2'b0, release_reg});
    assign env_sum  = $signed({5'b0, env_reg}) + 24'(rnd16);
    always_comb
    begin
        if (env_sum < 24'sd0)
        begin
            env_clamped = '0;
        end
        else if (env_sum > 24'sd524287)
        begin
            env_clamped = vggs_pkg::ENV_W'(vggs_pkg::ACC_MAX);
        end
        else
        begin
            env_clamped = env_sum[vggs_pkg::ENV_W-1:0];
        end
    end

    // Hard clip of the driven sample to plus or minus one.
    logic signed [16:0] p_clip;

    always_comb
    begin
        if (rnd12 > PW'(64'sd32768))
        begin
            p_clip = 17'sd32768;
        end
        else if (rnd12 < -PW'(64'sd32768))
        begin
            p_clip = -17'sd32768;
        end
        else
        begin
            p_clip = rnd12[16:0];
        end
    end

    // Scaled soft clip input and the odd continued-fraction term.
    logic signed [17:0] g_val;
    logic [4:0]         odd_k;

    assign g_val = rnd16[17:0];
    assign odd_k = {k_reg, 1'b0} - 5'd1;

    vggs_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    vggs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .den   (div_den),
        .rem0  (div_rem0),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // Configuration writes; the port is always ready.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        drive_next   = drive_reg;
        attack_next  = attack_reg;
        release_next = release_reg;
        thr_next     = thr_reg;
        if (cfg_valid)
        begin
            unique case (vggs_pkg::cfg_idx_t'(cfg_index))
                vggs_pkg::CFG_DRIVE_GAIN:     drive_next   = cfg_data;
                vggs_pkg::CFG_ATTACK_COEF:    attack_next  = cfg_data;
                vggs_pkg::CFG_RELEASE_COEF:   release_next = cfg_data;
                vggs_pkg::CFG_GATE_THRESHOLD: thr_next     = cfg_data[14:0];
                default:                      drive_next   = drive_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg   <= vggs_pkg::DRIVE_GAIN_RST;
            attack_reg  <= vggs_pkg::ATTACK_COEF_RST;
            release_reg <= vggs_pkg::RELEASE_COEF_RST;
            thr_reg     <= vggs_pkg::GATE_THRESHOLD_RST;
        end
        else
        begin
            drive_reg   <= drive_next;
            attack_reg  <= attack_next;
            release_reg <= release_next;
            thr_reg     <= thr_next;
        end
    end

    // Sequencer next-state and datapath logic.
    always_comb
    begin
        state_next      = state_reg;
        x_next          = x_reg;
        prev_in_next    = prev_in_reg;
        prev_dc_next    = prev_dc_reg;
        y_next          = y_reg;
        env_next        = env_reg;
        r_next          = r_reg;
        gain_next       = gain_reg;
        d_next          = d_reg;
        p_next          = p_reg;
        ax_next         = ax_reg;
        neg_next        = neg_reg;
        x2_next         = x2_reg;
        t_next          = t_reg;
        k_next          = k_reg;
        res_next        = res_reg;
        out_sample_next = out_sample_reg;
        out_env_next    = out_env_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mul_a           = '0;
        mul_b           = '0;
        div_req         = '0;
        div_den         = vggs_pkg::DIV_D_W'(thr_reg);
        div_rem0        = vggs_pkg::DIV_D_W'(env_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                // The pole product only depends on stored state, so it is
                // issued while waiting for a sample.
                mul_a = vggs_pkg::MUL_A_W'(prev_dc_reg);
                mul_b = vggs_pkg::MUL_B_W'(vggs_pkg::DC_POLE_Q16);
                if (in_valid)
                begin
                    x_next     = x_q15;
                    state_next = S_DC;
                end
            end
            S_DC:
            begin
                y_next       = dc_sat;
                prev_in_next = x_reg;
                prev_dc_next = dc_sat;
                state_next   = S_ENV_MUL;
            end
            S_ENV_MUL:
            begin
                mul_a      = vggs_pkg::MUL_A_W'(env_diff);
                mul_b      = $signed({1'b0, env_coef});
                state_next = S_ENV;
            end
            S_ENV:
            begin
                env_next   = env_clamped;
                state_next = S_GATE;
            end
            S_GATE:
            begin
                // A threshold of zero is never above the envelope, so the gate
                // stays open without a division.
                if (env_reg >= vggs_pkg::ENV_W'(thr_reg))
                begin
                    gain_next  = 17'd65536;
                    state_next = S_DMUL;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.lsb   = 1'b0;
                    div_req.nbits = vggs_pkg::DIV_N_W'(16);
                    state_next    = S_GDIV;
                end
            end
            S_GDIV:
            begin
                if (!div_busy)
                begin
                    r_next     = div_quot[15:0];
                    state_next = S_RR;
                end
            end
            S_RR:
            begin
                mul_a      = $signed({17'b0, r_reg});
                mul_b      = $signed({2'b0, r_reg});
                state_next = S_R2;
            end
            S_R2:
            begin
                mul_a      = $signed({1'b0, mul_p[31:0]});
                mul_b      = $signed({2'b0, r_reg});
                state_next = S_R3;
            end
            S_R3:
            begin
                gain_next  = cube[16:0];
                state_next = S_DMUL;
            end
            S_DMUL:
            begin
                mul_a      = vggs_pkg::MUL_A_W'(y_reg);
                mul_b      = $signed({1'b0, gain_reg});
                state_next = S_D;
            end
            S_D:
            begin
                d_next     = rnd16[19:0];
                state_next = S_PMUL;
            end
            S_PMUL:
            begin
                mul_a      = vggs_pkg::MUL_A_W'(d_reg);
                mul_b      = $signed({2'b0, drive_reg});
                state_next = S_P;
            end
            S_P:
            begin
                p_next     = p_clip;
                state_next = S_GMUL;
            end
            S_GMUL:
            begin
                mul_a      = vggs_pkg::MUL_A_W'(p_reg);
                mul_b      = vggs_pkg::MUL_B_W'(vggs_pkg::SAFE_GAIN_Q16);
                state_next = S_G;
            end
            S_G:
            begin
                neg_next   = g_val[17];
                ax_next    = g_val[17] ? 16'(-g_val) : g_val[15:0];
                state_next = S_X2MUL;
            end
            S_X2MUL:
            begin
                mul_a      = $signed({17'b0, ax_reg});
                mul_b      = $signed({2'b0, ax_reg});
                state_next = S_X2;
            end
            S_X2:
            begin
                x2_next    = mul_p[30:0];
                t_next     = vggs_pkg::DIV_D_W'({5'd19, 30'b0});
                k_next     = 4'd9;
                state_next = S_TSTART;
            end
            S_TSTART:
            begin
                // floor(x2 * 2^30 / t): the top of the numerator is x2 >> 1,
                // then bit zero of x2 and thirty zeros shift in.
                div_den       = t_reg;
                div_rem0      = vggs_pkg::DIV_D_W'(x2_reg[30:1]);
                div_req.start = 1'b1;
                div_req.lsb   = x2_reg[0];
                div_req.nbits = vggs_pkg::DIV_N_W'(31);
                state_next    = S_TDIV;
            end
            S_TDIV:
            begin
                if (!div_busy)
                begin
                    t_next = vggs_pkg::DIV_D_W'({odd_k, 30'b0})
                           + vggs_pkg::DIV_D_W'(div_quot[30:0]);
                    k_next = k_reg - 4'd1;
                    if (k_reg == 4'd1)
                    begin
                        state_next = S_FMUL;
                    end
                    else
                    begin
                        state_next = S_TSTART;
                    end
                end
            end
            S_FMUL:
            begin
                mul_a      = $signed({17'b0, ax_reg});
                mul_b      = vggs_pkg::MUL_B_W'(vggs_pkg::OUT_SCALE);
                state_next = S_FSTART;
            end
            S_FSTART:
            begin
                div_den       = t_reg;
                div_rem0      = vggs_pkg::DIV_D_W'(mul_p[30:1]);
                div_req.start = 1'b1;
                div_req.lsb   = mul_p[0];
                div_req.nbits = vggs_pkg::DIV_N_W'(16);
                state_next    = S_FDIV;
            end
            S_FDIV:
            begin
                if (!div_busy)
                begin
                    res_next   = neg_reg ? -$signed(div_quot[15:0])
                                         : $signed(div_quot[15:0]);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Wait here only while the output register still holds an
                // untaken beat.
                if (!out_valid_reg || !out_stall)
                begin
                    out_sample_next = res_reg;
                    out_env_next    = env_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            prev_in_reg   <= '0;
            prev_dc_reg   <= '0;
            env_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            prev_in_reg   <= prev_in_next;
            prev_dc_reg   <= prev_dc_next;
            env_reg       <= env_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        r_reg          <= r_next;
        gain_reg       <= gain_next;
        d_reg          <= d_next;
        p_reg          <= p_next;
        ax_reg         <= ax_next;
        neg_reg        <= neg_next;
        x2_reg         <= x2_next;
        t_reg          <= t_next;
        k_reg          <= k_next;
        res_reg        <= res_next;
        out_sample_reg <= out_sample_next;
        out_env_reg    <= out_env_next;
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign out_sample     = out_sample_reg;
    assign envelope_level = out_env_reg;

endmodule

// ----- sv/vggs_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on vggs_pkg for operand widths.
module vggs_mul
(
    input  logic                                  clk,
    input  logic signed [vggs_pkg::MUL_A_W-1:0]   a,
    input  logic signed [vggs_pkg::MUL_B_W-1:0]   b,
    output logic signed [vggs_pkg::MUL_P_W-1:0]   p
);

    logic signed [vggs_pkg::MUL_P_W-1:0] p_reg;
    logic signed [vggs_pkg::MUL_P_W-1:0] p_next;

    assign p_next = vggs_pkg::MUL_P_W'(a) * vggs_pkg::MUL_P_W'(b);
    assign p      = p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

endmodule

// ----- sv/vggs_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// The caller loads a partial remainder below the divisor plus the bits still to come.
// Depends on vggs_pkg for widths and the request struct.
module vggs_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  vggs_pkg::div_req_t                req,
    input  logic [vggs_pkg::DIV_D_W-1:0]      den,
    input  logic [vggs_pkg::DIV_D_W-1:0]      rem0,
    output logic                              busy,
    output logic [vggs_pkg::DIV_Q_W-1:0]      quot
);

    logic                             active_reg;
    logic                             active_next;
    logic [vggs_pkg::DIV_N_W-1:0]     cnt_reg;
    logic [vggs_pkg::DIV_N_W-1:0]     cnt_next;
    logic [vggs_pkg::DIV_D_W-1:0]     rem_reg;
    logic [vggs_pkg::DIV_D_W-1:0]     rem_next;
    logic [vggs_pkg::DIV_D_W-1:0]     den_reg;
    logic [vggs_pkg::DIV_D_W-1:0]     den_next;
    logic [vggs_pkg::DIV_Q_W-1:0]     quot_reg;
    logic [vggs_pkg::DIV_Q_W-1:0]     quot_next;
    logic                             nb_reg;
    logic                             nb_next;
    logic [vggs_pkg::DIV_D_W:0]       rem_sh;
    logic                             fits;

    assign rem_sh = {rem_reg, nb_reg};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        quot_next   = quot_reg;
        nb_next     = nb_reg;
        if (req.start)
        begin
            active_next = 1'b1;
            cnt_next    = req.nbits;
            rem_next    = rem0;
            den_next    = den;
            quot_next   = '0;
            nb_next     = req.lsb;
        end
        else if (active_reg)
        begin
            // Only the first shifted bit can be set; the rest are zeros.
            nb_next   = 1'b0;
            quot_next = {quot_reg[vggs_pkg::DIV_Q_W-2:0], fits};
            rem_next  = fits ? vggs_pkg::DIV_D_W'(rem_sh - {1'b0, den_reg})
                             : vggs_pkg::DIV_D_W'(rem_sh);
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == vggs_pkg::DIV_N_W'(1))
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
        nb_reg   <= nb_next;
    end

    assign busy = active_reg;
    assign quot = quot_reg;

endmodule
